// ===== sv/qihl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qihl_pkg
// Shared constants for the QUIC Initial long-header locator: status codes,
// header bit masks and parameter defaults.
// ----------------------------------------------------------------------------
package qihl_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 65536;
	localparam int unsigned MAX_ID_BYTES_DEF = 20;

	localparam logic [31:0] VERSION_V1 = 32'd1;

	localparam logic [7:0] LONG_FORM_MASK = 8'h80;
	localparam logic [7:0] FIXED_BIT_MASK = 8'h40;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_TRUNC       = 3'd1;
	localparam status_t ST_UNSUPPORTED = 3'd2;
	localparam status_t ST_FIXED_BIT   = 3'd3;
	localparam status_t ST_ID_LEN      = 3'd4;
	localparam status_t ST_MISMATCH    = 3'd5;

endpackage
`default_nettype wire

// ===== sv/quic_initial_header_locator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quic_initial_header_locator
// Byte-stream parser for a QUIC v1 Initial long header: checks form, fixed
// bit, version and type, skips connection IDs and token, decodes the payload
// length and reports offsets at the last byte of the buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one byte beat (data_byte, last_byte) per accepted
//   byte_valid while byte_stall is low; while it stays low, one beat per cycle is sustained.
//   Output channel: one result beat per buffer, raised on result_valid and
//   taken when result_stall is low. Bytes without last_byte make no beat.
//   Path: an accepted last byte passes the input register, the parse stage
//   and the result register before it shows on the result port.
//   Throughput: one byte per cycle while byte_stall is low, set by the single
//   parse stage that updates the header state registers on each byte taken.
//   Stalls: while the result register waits, non-last bytes keep flowing;
//   a last byte is held only when both result-side registers are full.
//   Configuration: accepted_version is written on cfg_valid; cfg_ready is
//   always high. Write it only while the block is idle.
//   Reset: arst_n clears all parse state and valid flags; the stored
//   accepted version returns to QUIC v1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module quic_initial_header_locator
	import qihl_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int unsigned MAX_ID_BYTES = MAX_ID_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] accepted_version,

	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,

	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       status,
	output logic [15:0]      plen_offset,
	output logic [3:0]       plen_size,
	output logic [15:0]      plen_value,
	output logic [15:0]      number_offset,
	output logic [15:0]      end_offset
);

	localparam int POS_W  = $clog2(BUFFER_BYTES + 1);
	localparam int ACC_W  = POS_W;
	localparam int SKIP_W = (POS_W > 8) ? POS_W : 8;
	localparam int CW     = ((POS_W > 16) ? POS_W : 16) + 1;

	localparam logic [3:0] PH_FIRST        = 4'd0;
	localparam logic [3:0] PH_VERSION      = 4'd1;
	localparam logic [3:0] PH_DCID_LEN     = 4'd2;
	localparam logic [3:0] PH_DCID_SKIP    = 4'd3;
	localparam logic [3:0] PH_SCID_LEN     = 4'd4;
	localparam logic [3:0] PH_SCID_SKIP    = 4'd5;
	localparam logic [3:0] PH_TOKLEN_FIRST = 4'd6;
	localparam logic [3:0] PH_TOKLEN_MORE  = 4'd7;
	localparam logic [3:0] PH_TOKEN_SKIP   = 4'd8;
	localparam logic [3:0] PH_PLEN_FIRST   = 4'd9;
	localparam logic [3:0] PH_PLEN_MORE    = 4'd10;
	localparam logic [3:0] PH_DONE         = 4'd11;

	function automatic logic [15:0] sat16(input logic [CW-1:0] v);
		sat16 = (v > CW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
	endfunction

	// configuration
	logic [31:0] version_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_V1;
		end else if (cfg_valid && cfg_ready) begin
			version_q <= accepted_version;
		end
	end

	// handshake and stage control
	logic       s1_valid;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       s2_valid;
	logic       result_valid_q;
	logic       out_free;
	logic       s2_free;
	logic       s1_go;
	logic       in_take;

	assign out_free   = !result_valid_q || !result_stall;
	assign s2_free    = !s2_valid || out_free;
	assign s1_go      = s1_valid && (!last_s1 || s2_free);
	assign byte_stall = s1_valid && !s1_go;
	assign in_take    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_take) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// parse state
	logic [3:0]        phase_q;
	logic [POS_W-1:0]  pos_q;
	logic [SKIP_W-1:0] skip_q;
	logic [ACC_W-1:0]  acc_q;
	logic              big_q;
	logic [2:0]        vleft_q;
	status_t           err_q;
	logic              kind_bad_q;
	logic              ver_bad_q;
	logic [POS_W-1:0]  len_off_q;
	logic [3:0]        len_size_q;
	logic [POS_W-1:0]  num_off_q;

	logic [3:0]        phase_n;
	logic [POS_W-1:0]  pos_n;
	logic [SKIP_W-1:0] skip_n;
	logic [ACC_W-1:0]  acc_n;
	logic              big_n;
	logic [2:0]        vleft_n;
	status_t           err_n;
	logic              kind_bad_n;
	logic              ver_bad_n;
	logic [POS_W-1:0]  len_off_n;
	logic [3:0]        len_size_n;
	logic [POS_W-1:0]  num_off_n;

	logic [ACC_W+7:0]  acc_wide;
	logic [ACC_W-1:0]  acc_sh;
	logic              big_sh;
	logic [7:0]        ver_byte;
	logic              ver_bad_sh;
	logic [3:0]        vsize;
	logic [2:0]        vmore;
	logic [ACC_W-1:0]  first_val;

	assign acc_wide   = {acc_q, byte_s1};
	assign acc_sh     = acc_wide[ACC_W-1:0];
	assign big_sh     = big_q || (acc_wide[ACC_W+7:ACC_W] != 8'd0);
	assign vsize      = 4'd1 << byte_s1[7:6];
	assign vmore      = 3'(vsize - 4'd1);
	assign first_val  = ACC_W'(byte_s1[5:0]);
	assign ver_bad_sh = ver_bad_q || (byte_s1 != ver_byte);

	always_comb begin
		case (vleft_q)
			3'd4:    ver_byte = version_q[31:24];
			3'd3:    ver_byte = version_q[23:16];
			3'd2:    ver_byte = version_q[15:8];
			default: ver_byte = version_q[7:0];
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		skip_n     = skip_q;
		acc_n      = acc_q;
		big_n      = big_q;
		vleft_n    = vleft_q;
		err_n      = err_q;
		kind_bad_n = kind_bad_q;
		ver_bad_n  = ver_bad_q;
		len_off_n  = len_off_q;
		len_size_n = len_size_q;
		num_off_n  = num_off_q;
		// drop bytes past the buffer size, count the rest
		if (pos_q < POS_W'(BUFFER_BYTES)) begin
			pos_n = pos_q + POS_W'(1);
			if (err_q == ST_OK) begin
				case (phase_q)
					PH_FIRST: begin
						if ((byte_s1 & LONG_FORM_MASK) == 8'd0) begin
							err_n = ST_UNSUPPORTED;
						end else if ((byte_s1 & FIXED_BIT_MASK) == 8'd0) begin
							err_n = ST_FIXED_BIT;
						end else begin
							kind_bad_n = (byte_s1[5:4] != 2'd0);
							ver_bad_n  = 1'b0;
							vleft_n    = 3'd4;
							phase_n    = PH_VERSION;
						end
					end
					PH_VERSION: begin
						ver_bad_n = ver_bad_sh;
						vleft_n   = vleft_q - 3'd1;
						if (vleft_q == 3'd1) begin
							if (ver_bad_sh || kind_bad_q) begin
								err_n = ST_UNSUPPORTED;
							end else begin
								phase_n = PH_DCID_LEN;
							end
						end
					end
					PH_DCID_LEN, PH_SCID_LEN: begin
						if (byte_s1 > 8'(MAX_ID_BYTES)) begin
							err_n = ST_ID_LEN;
						end else begin
							skip_n = SKIP_W'(byte_s1);
							if (phase_q == PH_DCID_LEN) begin
								phase_n = (byte_s1 != 8'd0) ? PH_DCID_SKIP : PH_SCID_LEN;
							end else begin
								phase_n = (byte_s1 != 8'd0) ? PH_SCID_SKIP : PH_TOKLEN_FIRST;
							end
						end
					end
					PH_DCID_SKIP: begin
						skip_n = skip_q - SKIP_W'(1);
						if (skip_q == SKIP_W'(1)) begin
							phase_n = PH_SCID_LEN;
						end
					end
					PH_SCID_SKIP: begin
						skip_n = skip_q - SKIP_W'(1);
						if (skip_q == SKIP_W'(1)) begin
							phase_n = PH_TOKLEN_FIRST;
						end
					end
					PH_TOKLEN_FIRST: begin
						acc_n   = first_val;
						big_n   = 1'b0;
						vleft_n = vmore;
						if (vmore == 3'd0) begin
							skip_n  = SKIP_W'(first_val);
							phase_n = (first_val != '0) ? PH_TOKEN_SKIP : PH_PLEN_FIRST;
						end else begin
							phase_n = PH_TOKLEN_MORE;
						end
					end
					PH_TOKLEN_MORE: begin
						acc_n   = acc_sh;
						big_n   = big_sh;
						vleft_n = vleft_q - 3'd1;
						if (vleft_q == 3'd1) begin
							// a token past the buffer never ends: pin the count high
							skip_n  = big_sh ? {SKIP_W{1'b1}} : SKIP_W'(acc_sh);
							phase_n = (big_sh || acc_sh != '0) ? PH_TOKEN_SKIP : PH_PLEN_FIRST;
						end
					end
					PH_TOKEN_SKIP: begin
						skip_n = skip_q - SKIP_W'(1);
						if (skip_q == SKIP_W'(1)) begin
							phase_n = PH_PLEN_FIRST;
						end
					end
					PH_PLEN_FIRST: begin
						len_off_n  = pos_q;
						len_size_n = vsize;
						acc_n      = first_val;
						big_n      = 1'b0;
						vleft_n    = vmore;
						if (vmore == 3'd0) begin
							num_off_n = pos_q + POS_W'(1);
							phase_n   = PH_DONE;
						end else begin
							phase_n = PH_PLEN_MORE;
						end
					end
					PH_PLEN_MORE: begin
						acc_n   = acc_sh;
						big_n   = big_sh;
						vleft_n = vleft_q - 3'd1;
						if (vleft_q == 3'd1) begin
							num_off_n = pos_q + POS_W'(1);
							phase_n   = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			pos_q      <= '0;
			skip_q     <= '0;
			acc_q      <= '0;
			big_q      <= 1'b0;
			vleft_q    <= 3'd0;
			err_q      <= ST_OK;
			kind_bad_q <= 1'b0;
			ver_bad_q  <= 1'b0;
			len_off_q  <= '0;
			len_size_q <= 4'd0;
			num_off_q  <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				phase_q    <= PH_FIRST;
				pos_q      <= '0;
				skip_q     <= '0;
				acc_q      <= '0;
				big_q      <= 1'b0;
				vleft_q    <= 3'd0;
				err_q      <= ST_OK;
				kind_bad_q <= 1'b0;
				ver_bad_q  <= 1'b0;
				len_off_q  <= '0;
				len_size_q <= 4'd0;
				num_off_q  <= '0;
			end else begin
				phase_q    <= phase_n;
				pos_q      <= pos_n;
				skip_q     <= skip_n;
				acc_q      <= acc_n;
				big_q      <= big_n;
				vleft_q    <= vleft_n;
				err_q      <= err_n;
				kind_bad_q <= kind_bad_n;
				ver_bad_q  <= ver_bad_n;
				len_off_q  <= len_off_n;
				len_size_q <= len_size_n;
				num_off_q  <= num_off_n;
			end
		end
	end

	// snapshot of the finished buffer
	status_t          pre_st;
	status_t          st_s2;
	logic [POS_W-1:0] pos_s2;
	logic [POS_W-1:0] len_off_s2;
	logic [3:0]       len_size_s2;
	logic [ACC_W-1:0] acc_s2;
	logic             big_s2;
	logic [POS_W-1:0] num_off_s2;

	always_comb begin
		if (err_n != ST_OK) begin
			pre_st = err_n;
		end else if (phase_n == PH_DONE) begin
			pre_st = ST_OK;
		end else if (phase_n == PH_TOKEN_SKIP) begin
			pre_st = ST_MISMATCH;
		end else begin
			pre_st = ST_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s1_go && last_s1) begin
			s2_valid <= 1'b1;
		end else if (out_free) begin
			s2_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			st_s2       <= pre_st;
			pos_s2      <= pos_n;
			len_off_s2  <= len_off_n;
			len_size_s2 <= len_size_n;
			acc_s2      <= acc_n;
			big_s2      <= big_n;
			num_off_s2  <= num_off_n;
		end
	end

	// result register
	logic [CW-1:0] end_sum;
	logic          ok_fin;
	status_t       st_fin;
	status_t       status_q;
	logic [15:0]   plen_offset_q;
	logic [3:0]    plen_size_q;
	logic [15:0]   plen_value_q;
	logic [15:0]   number_offset_q;
	logic [15:0]   end_offset_q;

	assign end_sum = CW'(num_off_s2) + CW'(acc_s2);

	always_comb begin
		st_fin = st_s2;
		if (st_s2 == ST_OK && (big_s2 || end_sum > CW'(pos_s2))) begin
			st_fin = ST_MISMATCH;
		end
	end

	assign ok_fin = (st_fin == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s2_valid) begin
			status_q        <= st_fin;
			plen_offset_q   <= ok_fin ? sat16(CW'(len_off_s2)) : 16'd0;
			plen_size_q     <= ok_fin ? len_size_s2 : 4'd0;
			plen_value_q    <= !ok_fin ? 16'd0 : (big_s2 ? 16'hFFFF : sat16(CW'(acc_s2)));
			number_offset_q <= ok_fin ? sat16(CW'(num_off_s2)) : 16'd0;
			end_offset_q    <= !ok_fin ? 16'd0 : (big_s2 ? 16'hFFFF : sat16(end_sum));
		end
	end

	assign result_valid  = result_valid_q;
	assign status        = status_q;
	assign plen_offset   = plen_offset_q;
	assign plen_size     = plen_size_q;
	assign plen_value    = plen_value_q;
	assign number_offset = number_offset_q;
	assign end_offset    = end_offset_q;

`ifndef SYNTH
	// an error, once latched, holds until the buffer ends
	a_err_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !(s1_go && last_s1)) |=> (err_q == $past(err_q)))
		else $error("latched error changed inside a buffer");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(BUFFER_BYTES))
		else $error("byte position beyond buffer size");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_OK) |->
		(plen_offset == 16'd0 && plen_size == 4'd0 && plen_value == 16'd0 &&
		number_offset == 16'd0 && end_offset == 16'd0))
		else $error("failed result carries nonzero fields");

	// offsets saturate, so the packet number may sit at the same ceiling
	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_OK) |->
		($onehot(plen_size) && number_offset >= plen_offset &&
		end_offset >= number_offset))
		else $error("inconsistent fields in good result");

	// a result beat only follows a last byte through both stages
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(s2_valid))
		else $error("result raised without a finished buffer");
`endif

endmodule
`default_nettype wire
